// ===== design/lfr_pkg.sv =====
// Shared constants, result type and helper functions for the link frame receiver.
`timescale 1ns / 1ps

package lfr_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h5c;
   localparam logic [7:0] ADDR_PRIMARY = 8'h01;
   localparam logic [7:0] ADDR_SECONDARY = 8'h03;

   localparam int unsigned INDEX_W = 12;
   localparam int unsigned LENGTH_W = 12;

   // Per-word result, as it leaves the frame tracker and sits in the output register.
   typedef struct packed {
      logic                  frame_abort;
      logic [LENGTH_W-1:0]   frame_length;
      logic                  frame_done;
      logic [7:0]            store_byte;
      logic [INDEX_W-1:0]    store_index;
      logic                  store_valid;
   } rsp_type;

   // Control field codes accepted in the frame header.
   function automatic logic known_control(input logic [7:0] c);
      return c inside {8'h03, 8'h07, 8'h0B, 8'h01, 8'h21, 8'h05, 8'h25, 8'h00, 8'h02};
   endfunction

   function automatic logic known_address(input logic [7:0] a);
      return a inside {ADDR_PRIMARY, ADDR_SECONDARY};
   endfunction

endpackage

// ===== design/lfr_tracker.sv =====
// Frame state machine: parses header, counts body words, reports store/done/abort.
`timescale 1ns / 1ps

module lfr_tracker #(
   parameter int unsigned MAX_PAYLOAD = 1024
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      rx_byte,
   output lfr_pkg::rsp_type res
);

   localparam int unsigned BODY_LIMIT = 2 * MAX_PAYLOAD + 5;
   localparam int unsigned PW = $clog2(BODY_LIMIT + 1);
   localparam int unsigned IW = (PW > lfr_pkg::INDEX_W) ? PW : lfr_pkg::INDEX_W;
   localparam logic [PW-1:0] LIMIT_POS = PW'(BODY_LIMIT);

   localparam logic [2:0] PH_IDLE = 3'd0;
   localparam logic [2:0] PH_FLAG = 3'd1;
   localparam logic [2:0] PH_ADDR = 3'd2;
   localparam logic [2:0] PH_CTRL = 3'd3;
   localparam logic [2:0] PH_BODY = 3'd4;

   logic [2:0]    phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    addr_ff, addr_in;
   logic [7:0]    ctrl_ff, ctrl_in;
   logic [IW-1:0] pos_wide;
   logic [IW-1:0] len_wide;

   assign pos_wide = IW'(pos_ff);
   assign len_wide = pos_wide + IW'(1);

   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      addr_in  = addr_ff;
      ctrl_in  = ctrl_ff;
      res      = '0;
      case (phase_ff)
         PH_FLAG: begin
            if (lfr_pkg::known_address(rx_byte)) begin
               res.store_valid = 1'b1;
               res.store_index = lfr_pkg::INDEX_W'(1);
               res.store_byte  = rx_byte;
               addr_in  = rx_byte;
               pos_in   = PW'(2);
               phase_in = PH_ADDR;
            end else if (rx_byte == lfr_pkg::FLAG_BYTE) begin
               res.store_valid = 1'b1;
               res.store_byte  = rx_byte;
               pos_in   = PW'(1);
               phase_in = PH_FLAG;
            end else begin
               res.frame_abort = 1'b1;
               pos_in   = '0;
               phase_in = PH_IDLE;
            end
         end
         PH_ADDR: begin
            if (lfr_pkg::known_control(rx_byte)) begin
               res.store_valid = 1'b1;
               res.store_index = lfr_pkg::INDEX_W'(2);
               res.store_byte  = rx_byte;
               ctrl_in  = rx_byte;
               pos_in   = PW'(3);
               phase_in = PH_CTRL;
            end else if (rx_byte == lfr_pkg::FLAG_BYTE) begin
               res.store_valid = 1'b1;
               res.store_byte  = rx_byte;
               pos_in   = PW'(1);
               phase_in = PH_FLAG;
            end else begin
               res.frame_abort = 1'b1;
               pos_in   = '0;
               phase_in = PH_IDLE;
            end
         end
         PH_CTRL: begin
            // header check must equal address xor control
            if (rx_byte == (addr_ff ^ ctrl_ff)) begin
               res.store_valid = 1'b1;
               res.store_index = lfr_pkg::INDEX_W'(3);
               res.store_byte  = rx_byte;
               pos_in   = PW'(4);
               phase_in = PH_BODY;
            end else if (rx_byte == lfr_pkg::FLAG_BYTE) begin
               res.store_valid = 1'b1;
               res.store_byte  = rx_byte;
               pos_in   = PW'(1);
               phase_in = PH_FLAG;
            end else begin
               res.frame_abort = 1'b1;
               pos_in   = '0;
               phase_in = PH_IDLE;
            end
         end
         PH_BODY: begin
            if (rx_byte == lfr_pkg::FLAG_BYTE) begin
               res.store_valid  = 1'b1;
               res.store_index  = pos_wide[lfr_pkg::INDEX_W-1:0];
               res.store_byte   = rx_byte;
               res.frame_done   = 1'b1;
               res.frame_length = len_wide[lfr_pkg::LENGTH_W-1:0];
               pos_in   = '0;
               phase_in = PH_IDLE;
            end else if (pos_ff < LIMIT_POS) begin
               res.store_valid = 1'b1;
               res.store_index = pos_wide[lfr_pkg::INDEX_W-1:0];
               res.store_byte  = rx_byte;
               pos_in = pos_ff + PW'(1);
            end else begin
               res.frame_abort = 1'b1;
               pos_in   = '0;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            // idle, and any unused code: wait for an opening flag
            pos_in   = '0;
            phase_in = PH_IDLE;
            if (rx_byte == lfr_pkg::FLAG_BYTE) begin
               res.store_valid = 1'b1;
               res.store_byte  = rx_byte;
               pos_in   = PW'(1);
               phase_in = PH_FLAG;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         addr_ff  <= '0;
         ctrl_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         addr_ff  <= addr_in;
         ctrl_ff  <= ctrl_in;
      end
   end

   a_abort_to_idle: assert property (@(posedge clock) disable iff (reset)
      (step && res.frame_abort) |=> (phase_ff == PH_IDLE && pos_ff == '0))
      else $error("abort did not return tracker to idle");

   a_done_is_flag: assert property (@(posedge clock) disable iff (reset)
      res.frame_done |-> (res.store_valid && res.store_byte == lfr_pkg::FLAG_BYTE))
      else $error("frame done without stored closing flag");

   a_store_xor_abort: assert property (@(posedge clock) disable iff (reset)
      !(res.store_valid && res.frame_abort))
      else $error("word both stored and aborted");

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= LIMIT_POS)
      else $error("position beyond body limit");

   a_body_has_header: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (pos_ff >= PW'(4)))
      else $error("body phase with position below header length");

endmodule

// ===== design/link_frame_receiver.sv =====
// Top level of the link frame receiver: input register, frame tracker, output register.
`timescale 1ns / 1ps
//
//  channel | dir | ports                          | contents
//  --------+-----+--------------------------------+------------------------------------
//  req     | in  | req_tvalid/tready/tdata[7:0]   | received line byte
//  rsp     | out | rsp_tvalid/tready/tdata[31:0], | one result word per received byte
//          |     | rsp_tuser[1:0], rsp_tlast      | tlast = frame done
//
//  rsp_tvalid is registered: a word passes the input register and then the output
//  register before it can leave; one word is accepted per cycle when the result side keeps up.
//  The tracker updates its state in the cycle a word moves from the input register
//  into the output register.
//  reset (synchronous, active high) empties both registers and returns the tracker to
//  idle. A stall on rsp holds the output word, then the input word, and then drops
//  req_tready; nothing is lost or repeated.

module link_frame_receiver #(
   parameter int unsigned MAX_PAYLOAD = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [11:0] store_index, [19:12] store_byte,
                                    // [31:20] frame_length
   output logic [1:0]  rsp_tuser,   // [0] store_valid, [1] frame_abort
   output logic        rsp_tlast    // frame_done
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             out_valid_ff, out_valid_in;
   lfr_pkg::rsp_type out_res_ff;
   lfr_pkg::rsp_type res;
   logic             advance;
   logic             req_fire;

   // Move the held word forward whenever the output register is free or being drained.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire = req_tvalid && req_tready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   lfr_tracker #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_tracker (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .rx_byte(in_byte_ff),
      .res    (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on handshake, hold otherwise.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_res_ff.frame_length, out_res_ff.store_byte, out_res_ff.store_index};
   assign rsp_tuser  = {out_res_ff.frame_abort, out_res_ff.store_valid};
   assign rsp_tlast  = out_res_ff.frame_done;

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("input word lost during stall");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      (!out_valid_ff) |-> req_tready)
      else $error("input blocked while output register empty");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_tready) |-> !advance)
      else $error("output word overwritten while stalled");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the link frame receiver: byte streams in, checked result words out.
`timescale 1ns / 1ps

module tb_top;

   // Payload limit of the instance under test; the predictor derives its overrun point from it.
   localparam int unsigned PAYLOAD_LIMIT = 1024;
   localparam int unsigned BODY_LIMIT = 2 * PAYLOAD_LIMIT + 5;
   localparam int unsigned LONGEST_BODY = BODY_LIMIT - 4;     // body bytes of a full frame
   localparam int unsigned ITEM_TARGET = 2400;                // words accepted in total
   localparam int unsigned CALM_TAIL = 120;                   // last words with no idling
   localparam int unsigned HOLD_CYCLES = 400;                 // long receiver hold-off
   localparam int unsigned SETTLE_CYCLES = 8;                 // settling time after the final drain
   localparam int unsigned CYCLE_LIMIT = 1000000;

   // The nine control codes a header may carry.
   localparam logic [7:0] CTRL_CODES [9] = '{8'h03, 8'h07, 8'h0B, 8'h01, 8'h21,
                                             8'h05, 8'h25, 8'h00, 8'h02};

   // Predicts the result word for each accepted byte and checks the words that leave.
   class frame_scoreboard;
      typedef enum logic [2:0] {ST_IDLE, ST_FLAG, ST_ADDR, ST_CTRL, ST_BODY} phase_type;

      phase_type            phase;
      int unsigned          position;
      logic [7:0]           addr_byte;
      logic [7:0]           ctrl_byte;
      lfr_pkg::rsp_type     expected_words[$];
      int unsigned          errors;
      int unsigned          words_checked;
      int unsigned          frames_done;
      int unsigned          frames_dropped;

      function new();
         phase = ST_IDLE;
         position = 0;
         addr_byte = '0;
         ctrl_byte = '0;
         errors = 0;
         words_checked = 0;
         frames_done = 0;
         frames_dropped = 0;
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction

      function lfr_pkg::rsp_type kept(input int unsigned idx, input logic [7:0] b);
         lfr_pkg::rsp_type w;
         w = '0;
         w.store_valid = 1'b1;
         w.store_index = idx[lfr_pkg::INDEX_W-1:0];
         w.store_byte = b;
         return w;
      endfunction

      // Advance the frame state by one accepted byte and queue the word it must produce.
      function void note_byte(input logic [7:0] b);
         lfr_pkg::rsp_type w;
         bit               ctrl_ok;
         int unsigned      len;
         w = '0;
         ctrl_ok = 1'b0;
         foreach (CTRL_CODES[i]) if (CTRL_CODES[i] == b) ctrl_ok = 1'b1;
         case (phase)
            ST_FLAG: begin
               if (b == lfr_pkg::ADDR_PRIMARY || b == lfr_pkg::ADDR_SECONDARY) begin
                  w = kept(1, b);
                  addr_byte = b;
                  position = 2;
                  phase = ST_ADDR;
               end else if (b == lfr_pkg::FLAG_BYTE) begin
                  // repeated opening flag: store it again as byte 0
                  w = kept(0, b);
                  position = 1;
               end else begin
                  w.frame_abort = 1'b1;
                  position = 0;
                  phase = ST_IDLE;
               end
            end
            ST_ADDR: begin
               if (ctrl_ok) begin
                  w = kept(2, b);
                  ctrl_byte = b;
                  position = 3;
                  phase = ST_CTRL;
               end else if (b == lfr_pkg::FLAG_BYTE) begin
                  w = kept(0, b);
                  position = 1;
                  phase = ST_FLAG;
               end else begin
                  w.frame_abort = 1'b1;
                  position = 0;
                  phase = ST_IDLE;
               end
            end
            ST_CTRL: begin
               if (b == (addr_byte ^ ctrl_byte)) begin
                  w = kept(3, b);
                  position = 4;
                  phase = ST_BODY;
               end else if (b == lfr_pkg::FLAG_BYTE) begin
                  w = kept(0, b);
                  position = 1;
                  phase = ST_FLAG;
               end else begin
                  // bad header check drops the frame and clears the position
                  w.frame_abort = 1'b1;
                  position = 0;
                  phase = ST_IDLE;
               end
            end
            ST_BODY: begin
               if (b == lfr_pkg::FLAG_BYTE) begin
                  len = position + 1;
                  w = kept(position, b);
                  w.frame_done = 1'b1;
                  w.frame_length = len[lfr_pkg::LENGTH_W-1:0];
                  position = 0;
                  phase = ST_IDLE;
               end else if (position < BODY_LIMIT) begin
                  w = kept(position, b);
                  position++;
               end else begin
                  // body overrun: drop the byte and the frame
                  w.frame_abort = 1'b1;
                  position = 0;
                  phase = ST_IDLE;
               end
            end
            default: begin
               position = 0;
               if (b == lfr_pkg::FLAG_BYTE) begin
                  w = kept(0, b);
                  position = 1;
                  phase = ST_FLAG;
               end
            end
         endcase
         expected_words.push_back(w);
      endfunction

      function void compare(input string field, input logic [11:0] exp_v,
                            input logic [11:0] act_v);
         if (exp_v !== act_v) begin
            $error("result word %0d: %s expected 0x%0h, got 0x%0h",
                   words_checked, field, exp_v, act_v);
            errors++;
         end
      endfunction

      // Check one accepted result word against the oldest expectation.
      function void check_word(input logic [31:0] data, input logic [1:0] user,
                               input logic last);
         lfr_pkg::rsp_type e;
         if (expected_words.size() == 0) begin
            $error("result word with nothing expected: tdata 0x%0h tuser %0b tlast %0b",
                   data, user, last);
            errors++;
            return;
         end
         e = expected_words.pop_front();
         compare("store_valid", 12'(e.store_valid), 12'(user[0]));
         compare("store_index", e.store_index, data[11:0]);
         compare("store_byte", 12'(e.store_byte), 12'(data[19:12]));
         compare("frame_done", 12'(e.frame_done), 12'(last));
         compare("frame_length", e.frame_length, data[31:20]);
         compare("frame_abort", 12'(e.frame_abort), 12'(user[1]));
         if (e.frame_done) frames_done++;
         if (e.frame_abort) frames_dropped++;
         words_checked++;
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;      // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [11:0] store_index, [19:12] store_byte,
                                    // [31:20] frame_length
   logic [1:0]  rsp_tuser;          // [0] store_valid, [1] frame_abort
   logic        rsp_tlast;          // frame_done

   frame_scoreboard sb;
   int unsigned     cycle_count = 0;
   int unsigned     sent_words = 0;     // words accepted by the block
   bit              calm = 1'b0;        // no idling on either side near the end
   bit              sender_steady = 1'b0;
   bit              hold_request = 1'b0;
   int unsigned     holds_done = 0;

   link_frame_receiver #(
      .MAX_PAYLOAD(PAYLOAD_LIMIT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Guard against a hang: give up well past the slowest correct run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Check every word taken on the result side, using values sampled at the edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // Result-side ready: random stall bursts, open stretches, and one long hold-off on request.
   initial begin
      int unsigned stall_left;
      int unsigned open_left;
      stall_left = 0;
      open_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (hold_request) begin
            // hold off long enough for both registers to fill and req_tready to drop
            hold_request = 1'b0;
            holds_done++;
            stall_left = HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (open_left > 0) begin
            rsp_tready <= 1'b1;
            open_left--;
         end else if (!calm && !reset && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 15) - 1;
            rsp_tready <= 1'b0;
         end else begin
            if ($urandom_range(0, 15) == 0) open_left = $urandom_range(20, 80);
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offer one byte, holding it until the block takes it; idle before it at random.
   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(0, 49) == 0) sender_steady = !sender_steady;
      if (!calm && !sender_steady && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(b);
      sent_words++;
   endtask

   // Drop valid and wait until every expected word has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      do b = 8'($urandom); while (b == lfr_pkg::FLAG_BYTE);
      return b;
   endfunction

   // Well-formed frame with random header and body; optionally leave off the closing flag.
   task automatic send_frame(input int unsigned body_len, input bit close_it);
      logic [7:0] a;
      logic [7:0] c;
      a = $urandom_range(0, 1) ? lfr_pkg::ADDR_PRIMARY : lfr_pkg::ADDR_SECONDARY;
      c = CTRL_CODES[$urandom_range(0, 8)];
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) send_byte(lfr_pkg::FLAG_BYTE);
      send_byte(lfr_pkg::FLAG_BYTE);
      send_byte(a);
      send_byte(c);
      send_byte(a ^ c);
      repeat (body_len) send_byte(body_byte());
      if (close_it) send_byte(lfr_pkg::FLAG_BYTE);
   endtask

   // Frame with one header byte replaced by a random value, then a short tail.
   task automatic send_broken_frame();
      logic [7:0] hdr [4];
      int unsigned k;
      hdr[0] = lfr_pkg::FLAG_BYTE;
      hdr[1] = $urandom_range(0, 1) ? lfr_pkg::ADDR_PRIMARY : lfr_pkg::ADDR_SECONDARY;
      hdr[2] = CTRL_CODES[$urandom_range(0, 8)];
      hdr[3] = hdr[1] ^ hdr[2];
      k = $urandom_range(1, 3);
      hdr[k] = 8'($urandom);
      for (int i = 0; i < 4; i++) send_byte(hdr[i]);
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
      if ($urandom_range(0, 1)) send_byte(lfr_pkg::FLAG_BYTE);
   endtask

   initial begin
      logic [7:0]  script[$];
      int unsigned pick;
      bit          overrun_done;
      bit          hold_done;
      bit          pause_done;
      overrun_done = 1'b0;
      hold_done = 1'b0;
      pause_done = 1'b0;
      sb = new();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle noise, repeated flag, flag restarts in address and control wait,
      // a good frame with extreme body bytes, each way of a bad header, an empty body.
      script = '{8'h00, 8'hff,
                 lfr_pkg::FLAG_BYTE, lfr_pkg::FLAG_BYTE, lfr_pkg::ADDR_SECONDARY,
                 lfr_pkg::FLAG_BYTE,
                 lfr_pkg::ADDR_PRIMARY, CTRL_CODES[4], lfr_pkg::FLAG_BYTE,
                 lfr_pkg::ADDR_SECONDARY, CTRL_CODES[1],
                 lfr_pkg::ADDR_SECONDARY ^ CTRL_CODES[1],
                 8'h00, 8'hff, lfr_pkg::FLAG_BYTE,
                 lfr_pkg::FLAG_BYTE, 8'h02,
                 lfr_pkg::FLAG_BYTE, lfr_pkg::ADDR_PRIMARY, 8'h04,
                 lfr_pkg::FLAG_BYTE, lfr_pkg::ADDR_PRIMARY, CTRL_CODES[7], 8'h00,
                 lfr_pkg::FLAG_BYTE, lfr_pkg::ADDR_PRIMARY, CTRL_CODES[7],
                 lfr_pkg::ADDR_PRIMARY, lfr_pkg::FLAG_BYTE};
      foreach (script[i]) send_byte(script[i]);
      wait_drained();

      // Random: mostly well-formed frames, plus broken headers and line noise.
      while (sent_words < ITEM_TARGET) begin
         calm = (sent_words + CALM_TAIL >= ITEM_TARGET);
         if (!hold_done && sent_words >= 100) begin
            // keep offering while the result side holds off
            hold_done = 1'b1;
            hold_request = 1'b1;
         end
         if (!overrun_done && sent_words >= 200) begin
            // one byte past the largest body: the frame is dropped
            overrun_done = 1'b1;
            send_frame(LONGEST_BODY + 1, 1'b0);
         end
         if (!pause_done && sent_words >= ITEM_TARGET - 100) begin
            pause_done = 1'b1;
            wait_drained();
         end
         pick = $urandom_range(0, 99);
         if (pick < 72) send_frame($urandom_range(0, 24), 1'b1);
         else if (pick < 88) send_broken_frame();
         else repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("summary: %0d result words checked, %0d frames completed, %0d dropped,",
               sb.words_checked, sb.frames_done, sb.frames_dropped);
      $display("summary: %0d long hold-off, a drain pause and a body overrun included",
               holds_done);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/lfr_pkg.sv
design/lfr_tracker.sv
design/link_frame_receiver.sv
verif/tb_top.sv
